// ===== rtl/irpd_pkg.sv =====
// Shared types and constants for the pulse-distance infrared transmitter.
// Holds the frame phase encoding, register indexes, reset timings and the
// structs passed between the top level and the frame sequencer.
package irpd_pkg;

    localparam int FRAME_BITS   = 32;
    localparam int TICK_W       = 16;
    localparam int CODE_W       = 32;
    localparam int BITPOS_W     = 6;
    localparam int CFG_INDEX_W  = 3;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CARRIER_HALF = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEADER_MARK  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEADER_SPACE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_MARK     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_SPACE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_SPACE   = 3'd5;

    // Timing values after reset, in ticks.
    localparam logic [TICK_W-1:0] RST_CARRIER_HALF = 16'd13;
    localparam logic [TICK_W-1:0] RST_LEADER_MARK  = 16'd4500;
    localparam logic [TICK_W-1:0] RST_LEADER_SPACE = 16'd4500;
    localparam logic [TICK_W-1:0] RST_BIT_MARK     = 16'd560;
    localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 16'd1690;
    localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 16'd560;

    typedef enum logic [6:0] {
        PH_IDLE        = 7'b0000001,
        PH_LEAD_MARK   = 7'b0000010,
        PH_LEAD_SPACE  = 7'b0000100,
        PH_BIT_MARK    = 7'b0001000,
        PH_BIT_SPACE   = 7'b0010000,
        PH_STOP_MARK   = 7'b0100000,
        PH_STOP_SPACE  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] carrier_half;
        logic [TICK_W-1:0] leader_mark;
        logic [TICK_W-1:0] leader_space;
        logic [TICK_W-1:0] bit_mark;
        logic [TICK_W-1:0] one_space;
        logic [TICK_W-1:0] zero_space;
    } t_timing;

    typedef struct packed {
        logic rejected;
        logic busy;
        logic ir_level;
    } t_result;

endpackage

// ===== rtl/ir_pulse_distance_transmitter.sv =====
// Top level of the pulse-distance infrared transmitter: stream handshakes,
// timing registers and the result register. Depends on irpd_pkg and
// irpd_sequencer.
//
// Usage: each input transfer carries one item. tuser = 0 is a tick that
// advances the waveform by one time unit; tuser = 1 is a send whose tdata is
// the 32-bit code word, sent bit 0 first after a leader mark and space and
// followed by a stop mark and zero-space. Every item yields exactly one
// result transfer: bit 0 the emitter level, bit 1 busy, bit 2 rejected (a
// send that arrived while a frame was in progress).
// The result of an item is registered: it sits in the output register at
// the clock edge after its transfer. Throughput is one item per cycle while
// the output is not stalled; the frame sequencer updates its state once per
// item, and the only limit is the output register, which takes a new result
// whenever it is empty or being drained in the same cycle.
// When the receiver stalls, the result is held and the input is stalled too
// once the output register is full. Reset empties the output register,
// stops any frame and restores the default timing registers. The timing
// registers are written over the configuration channel (always ready) and
// should be changed only while the block is idle.
module ir_pulse_distance_transmitter
    import irpd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Input stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [CODE_W-1:0]       s_axis_tdata,   // [31:0] code_word
    input  logic                    s_axis_tuser,   // [0] opcode
    // Result stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // [0] ir_level, [1] busy_res,
                                                    // [2] rejected, [7:3] zero
    // Configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [TICK_W-1:0]       i_cfg_data
);

    t_timing    r_timing;
    t_result    r_result;
    t_result    seq_result;
    logic       r_out_valid;
    logic       in_xfer;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.carrier_half <= RST_CARRIER_HALF;
            r_timing.leader_mark  <= RST_LEADER_MARK;
            r_timing.leader_space <= RST_LEADER_SPACE;
            r_timing.bit_mark     <= RST_BIT_MARK;
            r_timing.one_space    <= RST_ONE_SPACE;
            r_timing.zero_space   <= RST_ZERO_SPACE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CARRIER_HALF: r_timing.carrier_half <= i_cfg_data;
                REG_LEADER_MARK:  r_timing.leader_mark  <= i_cfg_data;
                REG_LEADER_SPACE: r_timing.leader_space <= i_cfg_data;
                REG_BIT_MARK:     r_timing.bit_mark     <= i_cfg_data;
                REG_ONE_SPACE:    r_timing.one_space    <= i_cfg_data;
                REG_ZERO_SPACE:   r_timing.zero_space   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    irpd_sequencer u_sequencer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_xfer),
        .i_opcode    (s_axis_tuser),
        .i_code_word (s_axis_tdata),
        .i_timing    (r_timing),
        .o_result    (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= seq_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_result.rejected, r_result.busy, r_result.ir_level};

    // A rejected send can only happen while a frame carries on.
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.rejected |-> r_result.busy)
        else $error("rejected result without busy");

    // The emitter is driven only inside a frame.
    a_ir_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.ir_level |-> r_result.busy)
        else $error("emitter high outside a frame");

    // An accepted send starts a frame with the pin low.
    a_send_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (s_axis_tuser == OP_SEND) && !seq_result.rejected |=>
            r_out_valid && r_result.busy && !r_result.ir_level && !r_result.rejected)
        else $error("send did not start a frame");

endmodule

// ===== rtl/irpd_sequencer.sv =====
// Frame sequencer of the infrared transmitter: phase, counters, carrier and
// shift word, advanced once per accepted item. Depends on irpd_pkg.
module irpd_sequencer
    import irpd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_opcode,
    input  logic [CODE_W-1:0]   i_code_word,
    input  t_timing             i_timing,
    output t_result             o_result
);

    t_phase                 r_phase,     n_phase;
    logic [BITPOS_W-1:0]    r_bit_pos,   n_bit_pos;
    logic [TICK_W-1:0]      r_phase_cnt, n_phase_cnt;
    logic [TICK_W-1:0]      r_car_cnt,   n_car_cnt;
    logic                   r_pin,       n_pin;
    logic [CODE_W-1:0]      r_shift,     n_shift;

    logic                   busy;
    logic                   rejected;
    logic [TICK_W-1:0]      cnt_inc;
    logic [TICK_W-1:0]      car_inc;
    logic [BITPOS_W:0]      pos_inc;
    logic [TICK_W-1:0]      space_len;

    assign cnt_inc   = r_phase_cnt + 1'b1;
    assign car_inc   = r_car_cnt + 1'b1;
    assign pos_inc   = {1'b0, r_bit_pos} + 1'b1;
    assign space_len = r_shift[0] ? i_timing.one_space : i_timing.zero_space;

    // Any code other than a known busy phase counts as idle.
    assign busy = (r_phase == PH_LEAD_MARK)  || (r_phase == PH_LEAD_SPACE) ||
                  (r_phase == PH_BIT_MARK)   || (r_phase == PH_BIT_SPACE)  ||
                  (r_phase == PH_STOP_MARK)  || (r_phase == PH_STOP_SPACE);

    always_comb begin
        n_phase     = r_phase;
        n_bit_pos   = r_bit_pos;
        n_phase_cnt = r_phase_cnt;
        n_car_cnt   = r_car_cnt;
        n_pin       = r_pin;
        n_shift     = r_shift;
        rejected    = 1'b0;

        if (i_opcode == OP_SEND) begin
            if (!busy) begin
                n_shift     = i_code_word;
                n_bit_pos   = '0;
                n_phase     = PH_LEAD_MARK;
                n_phase_cnt = '0;
                n_car_cnt   = '0;
                n_pin       = 1'b0;
            end else begin
                rejected = 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_LEAD_MARK, PH_BIT_MARK, PH_STOP_MARK: begin
                    if (cnt_inc >= ((r_phase == PH_LEAD_MARK) ? i_timing.leader_mark
                                                              : i_timing.bit_mark)) begin
                        // Mark over: pin forced low and the following space begins.
                        n_phase     = (r_phase == PH_LEAD_MARK) ? PH_LEAD_SPACE :
                                      (r_phase == PH_BIT_MARK)  ? PH_BIT_SPACE :
                                                                  PH_STOP_SPACE;
                        n_phase_cnt = '0;
                        n_car_cnt   = '0;
                        n_pin       = 1'b0;
                    end else begin
                        n_phase_cnt = cnt_inc;
                        if (car_inc >= i_timing.carrier_half) begin
                            n_car_cnt = '0;
                            n_pin     = ~r_pin;
                        end else begin
                            n_car_cnt = car_inc;
                        end
                    end
                end
                PH_LEAD_SPACE: begin
                    n_phase_cnt = cnt_inc;
                    if (cnt_inc >= i_timing.leader_space) begin
                        n_bit_pos   = '0;
                        n_phase     = PH_BIT_MARK;
                        n_phase_cnt = '0;
                        n_car_cnt   = '0;
                        n_pin       = 1'b0;
                    end
                end
                PH_BIT_SPACE: begin
                    n_phase_cnt = cnt_inc;
                    if (cnt_inc >= space_len) begin
                        n_shift     = {1'b0, r_shift[CODE_W-1:1]};
                        n_phase_cnt = '0;
                        n_car_cnt   = '0;
                        n_pin       = 1'b0;
                        if (pos_inc >= (BITPOS_W+1)'(FRAME_BITS)) begin
                            n_phase = PH_STOP_MARK;
                        end else begin
                            n_bit_pos = pos_inc[BITPOS_W-1:0];
                            n_phase   = PH_BIT_MARK;
                        end
                    end
                end
                PH_STOP_SPACE: begin
                    n_phase_cnt = cnt_inc;
                    if (cnt_inc >= i_timing.zero_space) begin
                        n_phase     = PH_IDLE;
                        n_phase_cnt = '0;
                        n_car_cnt   = '0;
                        n_pin       = 1'b0;
                    end
                end
                default: begin
                    n_phase     = PH_IDLE;
                    n_phase_cnt = '0;
                    n_car_cnt   = '0;
                    n_pin       = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_pos   <= '0;
            r_phase_cnt <= '0;
            r_car_cnt   <= '0;
            r_pin       <= 1'b0;
            r_shift     <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_bit_pos   <= n_bit_pos;
            r_phase_cnt <= n_phase_cnt;
            r_car_cnt   <= n_car_cnt;
            r_pin       <= n_pin;
            r_shift     <= n_shift;
        end
    end

    assign o_result.rejected = rejected;
    assign o_result.ir_level = n_pin;
    assign o_result.busy     = (n_phase == PH_LEAD_MARK) || (n_phase == PH_LEAD_SPACE) ||
                               (n_phase == PH_BIT_MARK)  || (n_phase == PH_BIT_SPACE)  ||
                               (n_phase == PH_STOP_MARK) || (n_phase == PH_STOP_SPACE);

endmodule
